// ===== rtl/lfba_pkg.sv =====
// ----------------------------------------------------------------------------
// lfba_pkg: shared types and constants of the linked free list allocator
// Request codes, result status codes, controller states and field widths.
// ----------------------------------------------------------------------------
package lfba_pkg;

  // Width of a block index and of one link entry
  localparam int unsigned BLOCK_W = 16;
  // Width of the used block count, which can reach the full index space
  localparam int unsigned COUNT_W = BLOCK_W + 1;
  // Number of distinct block indices
  localparam int unsigned INDEX_SPACE = 1 << BLOCK_W;
  // Default number of blocks managed
  localparam int unsigned NUM_BLOCKS_DEFAULT = 65536;

  // Request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_IDX = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // Controller states
  typedef enum logic {
    STATE_IDLE,
    STATE_EXEC
  } state_t;

endpackage

// ===== rtl/lfba_link_mem.sv =====
// ----------------------------------------------------------------------------
// lfba_link_mem: chain link memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read address is presented.
// ----------------------------------------------------------------------------
module lfba_link_mem #(
  parameter int unsigned DEPTH = lfba_pkg::NUM_BLOCKS_DEFAULT,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [lfba_pkg::BLOCK_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [lfba_pkg::BLOCK_W-1:0]  rd_data
);

  logic [lfba_pkg::BLOCK_W-1:0] mem [DEPTH];

  // Store a link on write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Fetch a link; the read data is registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/linked_free_list_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// linked_free_list_block_allocator_top: block allocator with a linked free list
//
// Usage:
//   Raise start with opcode and block_index while busy is low; the request
//   transfers at that clock edge. opcode OP_ALLOC hands out a block, OP_FREE
//   returns block_index to the free chain. Freed blocks form a LIFO chain
//   whose links live in a single-port-read, single-port-write memory.
//   Each request gives exactly one result: done is high for one cycle with
//   granted_block, status, used_count and free_count valid in that cycle.
//   The request is executed in STATE_EXEC and the result is registered from it.
//   Busy is high in the cycle after a transfer and low again while done is
//   shown, so a new request may transfer in the same cycle as the previous
//   result. The execute state comes from the link memory read: the head's link
//   is fetched at the transfer edge and used in the following cycle to advance
//   the head.
//   The receiver cannot stall; results must be taken when done is high.
//   Reset (rst, synchronous) empties the chain, sets the used count to one
//   (header block only) and the free count to zero. The link memory is not
//   cleared; only entries written by a free are ever used.
// ----------------------------------------------------------------------------
module linked_free_list_block_allocator_top #(
  parameter int unsigned NUM_BLOCKS = lfba_pkg::NUM_BLOCKS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [lfba_pkg::BLOCK_W-1:0]  block_index,
  output logic                          done,
  output logic [lfba_pkg::BLOCK_W-1:0]  granted_block,
  output logic [1:0]                    status,
  output logic [lfba_pkg::COUNT_W-1:0]  used_count,
  output logic [lfba_pkg::BLOCK_W-1:0]  free_count
);

  // Usable capacity, bounded by the index space
  localparam int unsigned CAP =
    (NUM_BLOCKS > lfba_pkg::INDEX_SPACE) ? lfba_pkg::INDEX_SPACE : NUM_BLOCKS;
  localparam int unsigned AW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [lfba_pkg::COUNT_W-1:0] CAP_COUNT = lfba_pkg::COUNT_W'(CAP);
  localparam logic [lfba_pkg::BLOCK_W-1:0] FREE_MAX = '1;

  lfba_pkg::state_t state, state_next;

  logic                          accept;
  logic                          req_op;
  logic [lfba_pkg::BLOCK_W-1:0]  req_block;

  logic [lfba_pkg::BLOCK_W-1:0]  free_head, free_head_next;
  logic [lfba_pkg::COUNT_W-1:0]  used_total, used_total_next;
  logic [lfba_pkg::BLOCK_W-1:0]  free_total, free_total_next;

  logic [lfba_pkg::BLOCK_W-1:0]  granted_next;
  logic [1:0]                    status_next;
  logic                          done_next;

  logic                          link_wr_en;
  logic [lfba_pkg::BLOCK_W-1:0]  link_rd_data;
  logic                          bad_free;

  assign busy   = (state != lfba_pkg::STATE_IDLE);
  assign accept = start && !busy;

  // Link memory: read the head's link at transfer, write a link on push
  lfba_link_mem #(
    .DEPTH (CAP)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (req_block[AW-1:0]),
    .wr_data (free_head),
    .rd_en   (accept),
    .rd_addr (free_head[AW-1:0]),
    .rd_data (link_rd_data)
  );

  // Hold the request for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= opcode;
      req_block <= block_index;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfba_pkg::STATE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign bad_free = (req_block == '0) ||
                    ({1'b0, req_block} >= used_total);

  // Next state, allocator update and result
  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    used_total_next = used_total;
    free_total_next = free_total;
    granted_next    = '0;
    status_next     = lfba_pkg::STATUS_OK;
    done_next       = 1'b0;
    link_wr_en      = 1'b0;
    case (state)
      lfba_pkg::STATE_IDLE: begin
        if (accept) begin
          state_next = lfba_pkg::STATE_EXEC;
        end
      end
      lfba_pkg::STATE_EXEC: begin
        state_next = lfba_pkg::STATE_IDLE;
        done_next  = 1'b1;
        if (req_op == lfba_pkg::OP_ALLOC) begin
          if (free_head != '0) begin
            // pop the chain head
            granted_next   = free_head;
            free_head_next = link_rd_data;
            if (free_total != '0) begin
              free_total_next = free_total - 1'b1;
            end
          end else if (used_total < CAP_COUNT) begin
            // extend the used region
            granted_next    = used_total[lfba_pkg::BLOCK_W-1:0];
            used_total_next = used_total + 1'b1;
          end else begin
            status_next = lfba_pkg::STATUS_FULL;
          end
        end else begin
          if (bad_free) begin
            status_next = lfba_pkg::STATUS_BAD_IDX;
          end else begin
            // push onto the chain
            link_wr_en     = 1'b1;
            free_head_next = req_block;
            if (free_total != FREE_MAX) begin
              free_total_next = free_total + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = lfba_pkg::STATE_IDLE;
      end
    endcase
  end

  // Allocator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      used_total <= lfba_pkg::COUNT_W'(1);
      free_total <= '0;
    end else begin
      free_head  <= free_head_next;
      used_total <= used_total_next;
      free_total <= free_total_next;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (done_next) begin
      granted_block <= granted_next;
      status        <= status_next;
      used_count    <= used_total_next;
      free_count    <= free_total_next;
    end
  end

  // A result follows only an execute cycle
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == lfba_pkg::STATE_EXEC)
    else $error("result without execute cycle");

  // A transferred request is executed in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == lfba_pkg::STATE_EXEC)
    else $error("request not executed");

  // Used count stays between the header block and the capacity
  assert property (@(posedge clk) disable iff (rst)
    (used_total != '0) && (used_total <= CAP_COUNT))
    else $error("used count out of range");

  // Chain head is always empty or a block inside the used region
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, free_head} < used_total)
    else $error("chain head beyond used region");

  // Status is never the unused code
  assert property (@(posedge clk) disable iff (rst)
    done |-> (status == lfba_pkg::STATUS_OK) || (status == lfba_pkg::STATUS_BAD_IDX) ||
             (status == lfba_pkg::STATUS_FULL))
    else $error("bad status code");

endmodule

// ===== sim/tb_linked_free_list_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_linked_free_list_block_allocator_top: self-checking bench of the allocator
// Feeds allocate and free requests through the start/busy handshake, predicts
// every result with a bench-side model of the free chain and the counters,
// and checks each done strobe field by field. Covers directed corner cases,
// random traffic under three sender idle rates, invalid frees and double
// frees that make the chain loop on itself.
// ----------------------------------------------------------------------------
module tb_linked_free_list_block_allocator_top;

  localparam int unsigned NUM_BLOCKS = lfba_pkg::NUM_BLOCKS_DEFAULT;
  localparam int unsigned CAPACITY   =
    (NUM_BLOCKS > lfba_pkg::INDEX_SPACE) ? lfba_pkg::INDEX_SPACE : NUM_BLOCKS;
  localparam int unsigned QUEUE_MAX  = 8;
  localparam int unsigned SETTLE_CYC = 6;

  typedef struct packed {
    logic                         op;
    logic [lfba_pkg::BLOCK_W-1:0] idx;
  } request_t;

  typedef struct packed {
    logic [lfba_pkg::BLOCK_W-1:0] granted;
    logic [1:0]                   status;
    logic [lfba_pkg::COUNT_W-1:0] used;
    logic [lfba_pkg::BLOCK_W-1:0] freed;
  } alloc_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         opcode = lfba_pkg::OP_ALLOC;
  logic [lfba_pkg::BLOCK_W-1:0] block_index = '0;
  logic                         done;
  logic [lfba_pkg::BLOCK_W-1:0] granted_block;
  logic [1:0]                   status;
  logic [lfba_pkg::COUNT_W-1:0] used_count;
  logic [lfba_pkg::BLOCK_W-1:0] free_count;

  // Bench copy of the allocator state
  logic [lfba_pkg::BLOCK_W-1:0] chain_link [lfba_pkg::INDEX_SPACE];
  logic [lfba_pkg::BLOCK_W-1:0] chain_head = '0;
  logic [lfba_pkg::COUNT_W-1:0] used_blocks = lfba_pkg::COUNT_W'(1);
  logic [lfba_pkg::BLOCK_W-1:0] chain_len = '0;

  request_t                     pending_requests [$];
  alloc_result_t                awaited_results [$];
  logic [lfba_pkg::BLOCK_W-1:0] granted_live [$];
  alloc_result_t                reply;
  alloc_result_t                want;

  int unsigned idle_pct = 17;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned full_hits = 0;
  int unsigned bad_idx_hits = 0;

  linked_free_list_block_allocator_top #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .block_index  (block_index),
    .done         (done),
    .granted_block(granted_block),
    .status       (status),
    .used_count   (used_count),
    .free_count   (free_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the bench state and return the result it must give
  function automatic alloc_result_t serve_request(input logic op,
                                                  input logic [lfba_pkg::BLOCK_W-1:0] idx);
    alloc_result_t r;
    r.granted = '0;
    r.status  = lfba_pkg::STATUS_OK;
    if (op == lfba_pkg::OP_ALLOC) begin
      if (chain_head != '0) begin
        // Pop the head; the count floors at zero when the chain has cycled
        r.granted  = chain_head;
        chain_head = chain_link[chain_head];
        if (chain_len != '0) chain_len = chain_len - 1'b1;
      end else if (used_blocks < CAPACITY) begin
        r.granted   = used_blocks[lfba_pkg::BLOCK_W-1:0];
        used_blocks = used_blocks + 1'b1;
      end else begin
        r.status = lfba_pkg::STATUS_FULL;
      end
    end else if (idx == '0 || {1'b0, idx} >= used_blocks) begin
      r.status = lfba_pkg::STATUS_BAD_IDX;
    end else begin
      // Push the block; a repeated free is pushed again
      chain_link[idx] = chain_head;
      chain_head      = idx;
      if (chain_len != '1) chain_len = chain_len + 1'b1;
    end
    r.used  = used_blocks;
    r.freed = chain_len;
    return r;
  endfunction

  // Request driver: predict on each transfer, then present the next item or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reply = serve_request(opcode, block_index);
        awaited_results.push_back(reply);
        requests_sent++;
        if (reply.status == lfba_pkg::STATUS_FULL) full_hits++;
        if (reply.status == lfba_pkg::STATUS_BAD_IDX) bad_idx_hits++;
        if (opcode == lfba_pkg::OP_ALLOC && reply.status == lfba_pkg::STATUS_OK)
          granted_live.push_back(reply.granted);
      end
      if ((start && !busy) || !start) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start       <= 1'b1;
          opcode      <= pending_requests[0].op;
          block_index <= pending_requests[0].idx;
          pending_requests.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // Result monitor: sample mid-cycle, done holds for the whole cycle
  always @(negedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none awaited, expected nothing, got block %0d status %0d",
                 $time, granted_block, status);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        check_field("granted_block", 32'(want.granted), 32'(granted_block));
        check_field("status", 32'(want.status), 32'(status));
        check_field("used_count", 32'(want.used), 32'(used_count));
        check_field("free_count", 32'(want.freed), 32'(free_count));
      end
    end
  end

  // Queue one request, holding off while the pending queue is full
  task automatic push_item(input logic op, input logic [lfba_pkg::BLOCK_W-1:0] idx);
    request_t req;
    req.op  = op;
    req.idx = idx;
    while (pending_requests.size() >= QUEUE_MAX) @(negedge clk);
    pending_requests.push_back(req);
  endtask

  // Wait until every request has transferred and every result has come back
  task automatic wait_drain();
    @(negedge clk);
    while (pending_requests.size() != 0 || start || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Mostly well-formed traffic: allocate, or free a block the bench holds
  task automatic random_request(input bit allow_double);
    int unsigned pick;
    int unsigned k;
    int unsigned lo;
    logic [lfba_pkg::BLOCK_W-1:0] idx;
    pick = $urandom_range(99);
    if (pick < 50 || (pick < 85 && granted_live.size() == 0)) begin
      push_item(lfba_pkg::OP_ALLOC, lfba_pkg::BLOCK_W'($urandom));
    end else if (pick < 85) begin
      k   = $urandom_range(granted_live.size() - 1);
      idx = granted_live[k];
      granted_live.delete(k);
      push_item(lfba_pkg::OP_FREE, idx);
    end else if (pick < 95 || !allow_double) begin
      // Keep invalid frees clear of blocks that queued allocates may still hand out
      lo = used_blocks + 2 * QUEUE_MAX;
      if (lo <= lfba_pkg::INDEX_SPACE - 1 && $urandom_range(1))
        idx = lfba_pkg::BLOCK_W'($urandom_range(lfba_pkg::INDEX_SPACE - 1, lo));
      else idx = '0;
      push_item(lfba_pkg::OP_FREE, idx);
    end else begin
      push_item(lfba_pkg::OP_FREE, lfba_pkg::BLOCK_W'($urandom_range(used_blocks - 1, 1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: first blocks, invalid frees, LIFO reuse, extend after empty chain
    push_item(lfba_pkg::OP_ALLOC, '1);
    push_item(lfba_pkg::OP_ALLOC, '0);
    push_item(lfba_pkg::OP_ALLOC, 16'h5A5A);
    push_item(lfba_pkg::OP_FREE, '0);
    push_item(lfba_pkg::OP_FREE, 16'd4);
    push_item(lfba_pkg::OP_FREE, '1);
    push_item(lfba_pkg::OP_FREE, 16'd3);
    push_item(lfba_pkg::OP_FREE, 16'd1);
    push_item(lfba_pkg::OP_ALLOC, '0);
    push_item(lfba_pkg::OP_ALLOC, '0);
    push_item(lfba_pkg::OP_ALLOC, '0);
    push_item(lfba_pkg::OP_FREE, 16'd2);
    push_item(lfba_pkg::OP_ALLOC, '1);
    wait_drain();

    // Rebuild the held set: the chain is empty after the directed part
    granted_live.delete();
    for (int unsigned i = 1; i < used_blocks; i++)
      granted_live.push_back(lfba_pkg::BLOCK_W'(i));

    repeat (400) random_request(1'b0);
    idle_pct = 71;
    repeat (400) random_request(1'b0);
    idle_pct = 0;
    repeat (400) random_request(1'b0);

    // Double free: the block loops on itself and allocates keep handing it out
    push_item(lfba_pkg::OP_FREE, 16'd5);
    push_item(lfba_pkg::OP_FREE, 16'd5);
    repeat (3) push_item(lfba_pkg::OP_ALLOC, '0);

    repeat (120) random_request(1'b1);
    wait_drain();

    $display("Run covered %0d requests and %0d checked results.", requests_sent, results_checked);
    $display("Store full seen %0d times, invalid frees %0d, final used count %0d.",
             full_hits, bad_idx_hits, used_blocks);
    if (mismatch_count == 0) begin
      $display("linked_free_list_block_allocator_top test passed");
    end else begin
      $display("linked_free_list_block_allocator_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("linked_free_list_block_allocator_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lfba_pkg.sv
rtl/lfba_link_mem.sv
rtl/linked_free_list_block_allocator_top.sv
sim/tb_linked_free_list_block_allocator_top.sv
